### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands shared by the RTL; ASSERT_OFF drops them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### rtl/ads_pkg.sv
// ----------------------------------------------------------------------------
// Ascending/descending sorter package
// Sizes and sequencer states of the exchange sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package ads_pkg;

   localparam int DATA_W    = 32;
   localparam int MAX_ITEMS = 32;
   localparam int IDX_W     = $clog2(MAX_ITEMS);
   localparam int CNT_W     = IDX_W + 1;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_LOAD_I,
      ST_GET_I,
      ST_CMP,
      ST_STORE_I,
      ST_EMIT_LOAD,
      ST_EMIT_HOLD
   } ads_state_type;

endpackage

`default_nettype wire

### rtl/ascending_descending_sorter.sv
// ----------------------------------------------------------------------------
// Ascending/descending sorter
// Collects a run of signed words, exchange-sorts them in place with one
// shared comparator, then streams them out ascending and then descending.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Payload
//  --------+-----------+----------------------------------------------------
//  req     | in        | tdata[31:0] value, tlast is_last
//  rsp     | out       | tdata[31:0] sorted_value, tuser[0] descending,
//          |           | tuser[1] overflow, tlast end_of_run
//
//  Words are accepted back to back while the run is collected. After the final
//  one the sort runs on a single comparator and one read port of the store,
//  then each result passes through a store read and then the output register,
//  and waits out any rsp stall. req_tready is low from the final transaction
//  until the last result is taken. Reset clears the count, the overflow flag
//  and the sequencer; the store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ascending_descending_sorter (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [ads_pkg::DATA_W-1:0]  req_tdata,   // [31:0] value
   input  wire logic                        req_tlast,   // is_last
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [ads_pkg::DATA_W-1:0]       rsp_tdata,   // [31:0] sorted_value
   output logic [1:0]                       rsp_tuser,   // [0] descending, [1] overflow
   output logic                             rsp_tlast    // end_of_run
);

   import ads_pkg::*;

   ads_state_type state_ff, state_in;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic              desc_ff, desc_in;
   logic [DATA_W-1:0] cur_ff, cur_in;

   logic [DATA_W-1:0] out_value_ff, out_value_in;
   logic              out_desc_ff, out_desc_in;
   logic              out_end_ff, out_end_in;
   logic              out_ovf_ff, out_ovf_in;

   logic [DATA_W-1:0] mem [MAX_ITEMS];
   logic [DATA_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [DATA_W-1:0] wr_data;

   logic              req_fire;
   logic              rsp_fire;
   logic [CNT_W-1:0]  i_next;
   logic [CNT_W-1:0]  j_next;
   logic              has_room;
   logic              is_less;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign i_next   = {1'b0, i_ff} + CNT_W'(1);
   assign j_next   = j_ff + CNT_W'(1);
   assign has_room = (count_ff < CNT_W'(MAX_ITEMS));
   assign is_less  = ($signed(rd_data_ff) < $signed(cur_ff));

   // Next state of the sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_FILL: begin
            if (req_fire && req_tlast) begin
               state_in = ST_LOAD_I;
            end
         end
         ST_LOAD_I: begin
            state_in = ST_GET_I;
         end
         ST_GET_I: begin
            state_in = (i_next == count_ff) ? ST_STORE_I : ST_CMP;
         end
         ST_CMP: begin
            if (j_next == count_ff) begin
               state_in = ST_STORE_I;
            end
         end
         ST_STORE_I: begin
            state_in = (i_next == count_ff) ? ST_EMIT_LOAD : ST_LOAD_I;
         end
         ST_EMIT_LOAD: begin
            state_in = ST_EMIT_HOLD;
         end
         ST_EMIT_HOLD: begin
            if (rsp_fire) begin
               state_in = (desc_ff && (k_ff == '0)) ? ST_FILL : ST_EMIT_LOAD;
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   // Datapath controls: store access, comparator, output register loads
   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      desc_in      = desc_ff;
      cur_in       = cur_ff;
      out_value_in = out_value_ff;
      out_desc_in  = out_desc_ff;
      out_end_in   = out_end_ff;
      out_ovf_in   = out_ovf_ff;
      rd_addr      = k_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_data      = req_tdata;
      case (state_ff)
         ST_FILL: begin
            // store while there is room, else flag the drop
            if (req_fire) begin
               if (has_room) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               i_in = '0;
            end
         end
         ST_LOAD_I: begin
            rd_addr = i_ff;
         end
         ST_GET_I: begin
            // hold position i in the working register, fetch i+1
            cur_in  = rd_data_ff;
            j_in    = i_next;
            rd_addr = i_next[IDX_W-1:0];
         end
         ST_CMP: begin
            // swap the smaller word into the working register
            if (is_less) begin
               wr_en   = 1'b1;
               wr_addr = j_ff[IDX_W-1:0];
               wr_data = cur_ff;
               cur_in  = rd_data_ff;
            end
            j_in    = j_next;
            rd_addr = j_next[IDX_W-1:0];
         end
         ST_STORE_I: begin
            // settle position i and advance
            wr_en   = 1'b1;
            wr_addr = i_ff;
            wr_data = cur_ff;
            i_in    = i_next[IDX_W-1:0];
            k_in    = '0;
            desc_in = 1'b0;
            rd_addr = '0;
         end
         ST_EMIT_LOAD: begin
            out_value_in = rd_data_ff;
            out_desc_in  = desc_ff;
            out_end_in   = desc_ff && (k_ff == '0);
            out_ovf_in   = ovf_ff;
         end
         ST_EMIT_HOLD: begin
            // advance the emit index once the result is taken
            if (rsp_fire) begin
               if (!desc_ff) begin
                  if ({1'b0, k_ff} + CNT_W'(1) == count_ff) begin
                     desc_in = 1'b1;
                  end else begin
                     k_in = k_ff + IDX_W'(1);
                  end
               end else if (k_ff == '0) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
               end else begin
                  k_in = k_ff - IDX_W'(1);
               end
               rd_addr = k_in;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         desc_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         desc_ff  <= desc_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      out_value_ff <= out_value_in;
      out_desc_ff  <= out_desc_in;
      out_end_ff   <= out_end_in;
      out_ovf_ff   <= out_ovf_in;
   end

   // Value store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign req_tready = (state_ff == ST_FILL);
   assign rsp_tvalid = (state_ff == ST_EMIT_HOLD);
   assign rsp_tdata  = out_value_ff;
   assign rsp_tuser  = {out_ovf_ff, out_desc_ff};
   assign rsp_tlast  = out_end_ff;

   `ASSERT_IMPLIES(a_no_overlap, clock, reset, req_tready, !rsp_tvalid, "accepting while emitting")
   `ASSERT_IMPLIES(a_count_cap, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_ITEMS), "count past capacity")
   `ASSERT_IMPLIES(a_end_desc, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser[0], "end of run outside descending pass")
   `ASSERT_NEXT(a_run_clear, clock, reset, rsp_fire && rsp_tlast, req_tready && (count_ff == '0) && !ovf_ff, "run state not cleared")

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Ascending/descending sorter testbench
// Sends runs of signed words and checks each sorted result against a local
// insertion-sorted copy of the run: the ascending pass, then the descending
// pass, the end-of-run flag and the overflow flag. Covers single-word runs,
// value extremes, repeated values, a full store, dropped words, a long
// receiver hold-off and random runs under random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DATA_W           = ads_pkg::DATA_W;
   localparam int STORE_ITEMS      = ads_pkg::MAX_ITEMS;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int STALL_LIMIT      = 4000;
   localparam int TAIL_CYCLES      = 40;

   typedef logic signed [DATA_W-1:0] word_type;

   typedef struct packed {
      word_type sorted_value;
      logic     descending;
      logic     end_of_run;
      logic     overflow;
   } sorted_word_type;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [DATA_W-1:0]  req_tdata  = '0;   // [31:0] value
   logic               req_tlast  = 1'b0; // is_last
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [DATA_W-1:0]  rsp_tdata;         // [31:0] sorted_value
   logic [1:0]         rsp_tuser;         // [0] descending, [1] overflow
   logic               rsp_tlast;         // end_of_run

   // Run state mirrored from accepted transactions
   word_type           held_sorted [STORE_ITEMS];
   int                 held_count   = 0;
   logic               dropped_seen = 1'b0;
   sorted_word_type    sorted_results_q [$];

   int                 error_count       = 0;
   int                 stall_cycles      = 0;
   bit                 req_idle_on       = 1'b1;
   bit                 rsp_idle_on       = 1'b1;
   bit                 long_hold_pending = 1'b0;

   ascending_descending_sorter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Insert one accepted word into the sorted run; on the final word queue
   // both passes and clear the run
   function automatic void take_word(word_type value, logic last);
      int              pos;
      sorted_word_type word;
      if (held_count < STORE_ITEMS) begin
         pos = held_count;
         while (pos > 0 && held_sorted[pos-1] > value) begin
            held_sorted[pos] = held_sorted[pos-1];
            pos--;
         end
         held_sorted[pos] = value;
         held_count++;
      end else begin
         dropped_seen = 1'b1;
      end
      if (last) begin
         for (int k = 0; k < held_count; k++) begin
            word = '{sorted_value: held_sorted[k], descending: 1'b0,
                     end_of_run: 1'b0, overflow: dropped_seen};
            sorted_results_q.push_back(word);
         end
         for (int k = held_count - 1; k >= 0; k--) begin
            word = '{sorted_value: held_sorted[k], descending: 1'b1,
                     end_of_run: (k == 0), overflow: dropped_seen};
            sorted_results_q.push_back(word);
         end
         held_count   = 0;
         dropped_seen = 1'b0;
      end
   endfunction

   // Track every accepted input transaction
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         take_word(word_type'(req_tdata), req_tlast);
      end
   end

   // Compare every accepted result with the oldest expected one
   always @(posedge clock) begin : check_results
      sorted_word_type got;
      sorted_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{sorted_value: word_type'(rsp_tdata), descending: rsp_tuser[0],
                 end_of_run: rsp_tlast, overflow: rsp_tuser[1]};
         if (sorted_results_q.size() == 0) begin
            $display("%0t: unexpected result: value %0d desc %0b end %0b ovf %0b",
                     $time, got.sorted_value, got.descending, got.end_of_run,
                     got.overflow);
            error_count++;
         end else begin
            want = sorted_results_q.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch: expected value %0d desc %0b end %0b ovf %0b",
                        $time, want.sorted_value, want.descending, want.end_of_run,
                        want.overflow);
               $display("%0t:           actual value %0d desc %0b end %0b ovf %0b",
                        $time, got.sorted_value, got.descending, got.end_of_run,
                        got.overflow);
               error_count++;
            end
         end
      end
   end

   // Drive rsp_tready: long hold-off on request, random stall bursts otherwise
   initial begin
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(negedge clock);
         end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // End the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Offer one word, with an optional idle burst first, and hold it until taken
   task automatic send_word(word_type value, logic last);
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sorted_results_q.size() != 0) @(posedge clock);
   endtask

   // Mostly full-range words, with extremes and a narrow band for repeats
   function automatic word_type pick_value();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return {1'b1, {(DATA_W-1){1'b0}}};
               1: return {1'b0, {(DATA_W-1){1'b1}}};
               2: return '0;
               default: return '1;
            endcase
         end
         1, 2: return word_type'(int'($urandom_range(0, 15)) - 8);
         default: return word_type'($urandom());
      endcase
   endfunction

   // Mostly short runs, some up to a full store, a few past it
   function automatic int pick_run_length();
      case ($urandom_range(0, 19))
         0: return $urandom_range(STORE_ITEMS + 1, STORE_ITEMS + 8);
         1, 2, 3: return $urandom_range(13, STORE_ITEMS);
         default: return $urandom_range(1, 12);
      endcase
   endfunction

   task automatic send_run(int length);
      for (int i = 0; i < length; i++) begin
         send_word(pick_value(), i == length - 1);
      end
   endtask

   task automatic test_single_word();
      send_word({1'b1, {(DATA_W-1){1'b0}}}, 1'b1);
      send_word({1'b0, {(DATA_W-1){1'b1}}}, 1'b1);
      stop_sending();
      wait_drained();
   endtask

   task automatic test_extremes();
      send_word({1'b0, {(DATA_W-1){1'b1}}}, 1'b0);
      send_word({1'b1, {(DATA_W-1){1'b0}}}, 1'b0);
      send_word('0, 1'b0);
      send_word('1, 1'b0);
      send_word(word_type'(1), 1'b0);
      send_word(word_type'(32'h5555_5555), 1'b0);
      send_word(word_type'(32'hAAAA_AAAA), 1'b1);
      stop_sending();
      wait_drained();
   endtask

   task automatic test_repeated_values();
      send_word(word_type'(5), 1'b0);
      send_word(word_type'(-5), 1'b0);
      send_word(word_type'(5), 1'b0);
      send_word(word_type'(5), 1'b0);
      send_word(word_type'(-5), 1'b0);
      send_word(word_type'(0), 1'b0);
      send_word(word_type'(5), 1'b1);
      stop_sending();
      wait_drained();
   endtask

   // Exactly full, then full with the final word dropped, then well past full
   task automatic test_full_store();
      send_run(STORE_ITEMS);
      send_run(STORE_ITEMS + 1);
      send_run(STORE_ITEMS + 8);
      stop_sending();
      wait_drained();
   endtask

   // Hold the receiver off while a second run queues behind the first
   task automatic test_long_hold_off();
      long_hold_pending = 1'b1;
      send_run(6);
      send_run(6);
      send_run(3);
      stop_sending();
      wait_drained();
   endtask

   task automatic test_random_runs(int word_budget);
      int sent;
      int length;
      sent = 0;
      while (sent < word_budget) begin
         length      = pick_run_length();
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         send_run(length);
         sent += length;
      end
      stop_sending();
      wait_drained();
   endtask

   task automatic test_back_to_back();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      for (int r = 0; r < 6; r++) begin
         send_run($urandom_range(1, 12));
      end
      stop_sending();
      wait_drained();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_single_word();
      test_extremes();
      test_repeated_values();
      test_full_store();
      test_long_hold_off();
      test_random_runs(80);
      test_back_to_back();

      // Let any stray result show up before the verdict
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && sorted_results_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

### files.f
+incdir+rtl
rtl/ads_pkg.sv
rtl/ascending_descending_sorter.sv
tb/testbench.sv
